// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the join engine RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// The consequent must hold at every edge where the antecedent holds.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/ejbp_pkg.sv -----
// ---------------------------------------------------------------------------
// Join engine package
// Sizes, codes, shared types and row functions of the build/probe join engine.
// ---------------------------------------------------------------------------
`default_nettype none

package ejbp_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 4;
   localparam int VALUE_BITS = 32;

   localparam int FIELD_BITS = 32;
   localparam int OUT_COLS   = 8;
   localparam int IN_COLS    = 4;
   localparam int KEY_SLOTS  = 4;
   localparam int POS_BITS   = 2;
   localparam int COL_BITS   = 3;
   localparam int ADDR_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_ROWS + 1);

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 8;

   typedef enum logic [1:0] {
      REQ_BUILD = 2'd0,
      REQ_PROBE = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_KEY_COUNT   = 3'd0,
      CSR_BUILD_KEYS  = 3'd1,
      CSR_PROBE_KEYS  = 3'd2,
      CSR_BUILD_ARITY = 3'd3,
      CSR_PROBE_ARITY = 3'd4
   } csr_idx_type;

   typedef logic [VALUE_BITS-1:0]                 val_type;
   typedef logic [FIELD_BITS-1:0]                 field_type;
   typedef logic [MAX_COLS-1:0][VALUE_BITS-1:0]   row_type;
   typedef logic [IN_COLS-1:0][FIELD_BITS-1:0]    in_row_type;
   typedef logic [OUT_COLS-1:0][FIELD_BITS-1:0]   out_row_type;
   typedef logic [POS_BITS-1:0]                   pos_type;

   typedef struct packed {
      logic [COL_BITS-1:0]                 kc;
      logic [COL_BITS-1:0]                 barity;
      logic [COL_BITS-1:0]                 parity;
      logic [KEY_SLOTS-1:0][POS_BITS-1:0]  bkey;
      logic [KEY_SLOTS-1:0][POS_BITS-1:0]  pkey;
      logic [MAX_COLS-1:0][POS_BITS-1:0]   keep;
      logic [COL_BITS-1:0]                 nkeep;
   } cfg_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      row_type              wdata;
      logic                 re;
      logic [ADDR_BITS-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic                busy;
      logic [CNT_BITS-1:0] row_count;
   } stat_type;

   function automatic field_type widen(val_type v);
      logic signed [VALUE_BITS-1:0] s;
      s = signed'(v);
      return FIELD_BITS'(s);
   endfunction

   function automatic val_type col_at(row_type r, pos_type pos, logic [COL_BITS-1:0] arity);
      val_type res;
      res = '0;
      for (int c = 0; c < MAX_COLS; c++) begin
         if ((c == int'(pos)) && (c < int'(arity))) begin
            res = r[c];
         end
      end
      return res;
   endfunction

   function automatic logic row_match(row_type st, row_type pr, cfg_type cfg);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < KEY_SLOTS; k++) begin
         if ((k < int'(cfg.kc)) &&
             (col_at(st, cfg.bkey[k], cfg.barity) != col_at(pr, cfg.pkey[k], cfg.parity))) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic out_row_type compose(row_type st, row_type pr, cfg_type cfg);
      out_row_type res;
      res = '0;
      for (int o = 0; o < OUT_COLS; o++) begin
         for (int c = 0; c < MAX_COLS; c++) begin
            if ((c == o) && (c < int'(cfg.barity))) begin
               res[o] = widen(st[c]);
            end
         end
         for (int i = 0; i < MAX_COLS; i++) begin
            if ((i < int'(cfg.nkeep)) && (o == int'(cfg.barity) + i)) begin
               res[o] = widen(col_at(pr, cfg.keep[i], cfg.parity));
            end
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ejbp_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module ejbp_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ejbp_csr.sv -----
// ---------------------------------------------------------------------------
// Join engine configuration registers
// Holds the key and arity registers and derives the clamped join setup.
// ---------------------------------------------------------------------------
`default_nettype none

module ejbp_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ejbp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [ejbp_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output ejbp_pkg::cfg_type                         cfg
);

   import ejbp_pkg::*;

   logic [COL_BITS-1:0] key_count_ff;
   logic [7:0]          build_keys_ff;
   logic [7:0]          probe_keys_ff;
   logic [COL_BITS-1:0] build_arity_ff;
   logic [COL_BITS-1:0] probe_arity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff   <= '0;
         build_keys_ff  <= '0;
         probe_keys_ff  <= '0;
         build_arity_ff <= COL_BITS'(MAX_COLS);
         probe_arity_ff <= COL_BITS'(MAX_COLS);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_COUNT:   key_count_ff   <= csr_data[COL_BITS-1:0];
            CSR_BUILD_KEYS:  build_keys_ff  <= csr_data[7:0];
            CSR_PROBE_KEYS:  probe_keys_ff  <= csr_data[7:0];
            CSR_BUILD_ARITY: build_arity_ff <= csr_data[COL_BITS-1:0];
            CSR_PROBE_ARITY: probe_arity_ff <= csr_data[COL_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   function automatic logic [COL_BITS-1:0] clamp_arity(logic [COL_BITS-1:0] a);
      logic [COL_BITS-1:0] res;
      res = a;
      if (a == '0) begin
         res = COL_BITS'(1);
      end else if (int'(a) > MAX_COLS) begin
         res = COL_BITS'(MAX_COLS);
      end
      return res;
   endfunction

   always_comb begin
      logic                is_key;
      logic [COL_BITS-1:0] n;
      cfg        = '0;
      cfg.kc     = (int'(key_count_ff) > KEY_SLOTS) ? COL_BITS'(KEY_SLOTS) : key_count_ff;
      cfg.barity = clamp_arity(build_arity_ff);
      cfg.parity = clamp_arity(probe_arity_ff);
      for (int k = 0; k < KEY_SLOTS; k++) begin
         cfg.bkey[k] = build_keys_ff[POS_BITS*k +: POS_BITS];
         cfg.pkey[k] = probe_keys_ff[POS_BITS*k +: POS_BITS];
      end
      n = '0;
      for (int j = 0; j < MAX_COLS; j++) begin
         is_key = 1'b0;
         for (int k = 0; k < KEY_SLOTS; k++) begin
            if ((k < int'(cfg.kc)) && (int'(cfg.pkey[k]) == j)) begin
               is_key = 1'b1;
            end
         end
         if ((j < int'(cfg.parity)) && !is_key) begin
            for (int s = 0; s < MAX_COLS; s++) begin
               if (s == int'(n)) begin
                  cfg.keep[s] = POS_BITS'(j);
               end
            end
            n = n + COL_BITS'(1);
         end
      end
      cfg.nkeep = n;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ejbp_scan.sv -----
// ---------------------------------------------------------------------------
// Join engine sequencer
// Stores build rows, scans the row store for probes and drives the results.
// ---------------------------------------------------------------------------
`default_nettype none

module ejbp_scan (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ejbp_pkg::cfg_type       cfg,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_type,
   input  wire ejbp_pkg::in_row_type    req_cols,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output ejbp_pkg::out_row_type        rsp_cols,
   output logic                         rsp_last,
   output logic                         rsp_status,
   output ejbp_pkg::ram_req_type        ram_req,
   input  wire ejbp_pkg::row_type       ram_rdata,
   output ejbp_pkg::stat_type           stat
);

   import ejbp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DROP
   } state_type;

   state_type           state_ff,     state_in;
   logic [CNT_BITS-1:0] row_count_ff, row_count_in;
   logic [CNT_BITS-1:0] issue_cnt_ff, issue_cnt_in;
   logic                eval_vld_ff,  eval_vld_in;
   row_type             prb_ff,       prb_in;
   logic                pend_vld_ff,  pend_vld_in;
   out_row_type         pend_ff,      pend_in;
   logic                rsp_vld_ff,   rsp_vld_in;
   out_row_type         rsp_cols_ff,  rsp_cols_in;
   logic                rsp_last_ff,  rsp_last_in;
   logic                rsp_stat_ff,  rsp_stat_in;

   logic    accept;
   logic    out_free;
   logic    match;
   logic    absorb;
   logic    more;
   logic    issue;
   row_type in_row;

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         in_row[c] = req_cols[c][VALUE_BITS-1:0];
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign match     = row_match(ram_rdata, prb_ff, cfg);
   assign absorb    = !eval_vld_ff || !match || !pend_vld_ff || out_free;
   assign more      = (issue_cnt_ff < row_count_ff);
   assign issue     = (state_ff == S_SCAN) && absorb && more;

   always_comb begin
      state_in     = state_ff;
      row_count_in = row_count_ff;
      issue_cnt_in = issue_cnt_ff;
      eval_vld_in  = eval_vld_ff;
      prb_in       = prb_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ready;
      rsp_cols_in  = rsp_cols_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_stat_in  = rsp_stat_ff;
      ram_req      = '0;
      ram_req.raddr = issue_cnt_ff[ADDR_BITS-1:0];
      ram_req.waddr = row_count_ff[ADDR_BITS-1:0];
      ram_req.wdata = in_row;
      ram_req.re    = issue;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_BUILD: begin
                     if (row_count_ff >= CNT_BITS'(MAX_ROWS)) begin
                        state_in = S_DROP;
                     end else begin
                        ram_req.we   = 1'b1;
                        row_count_in = row_count_ff + CNT_BITS'(1);
                     end
                  end
                  REQ_PROBE: begin
                     for (int c = 0; c < MAX_COLS; c++) begin
                        prb_in[c] = (c < int'(cfg.parity)) ? in_row[c] : '0;
                     end
                     issue_cnt_in = '0;
                     eval_vld_in  = 1'b0;
                     pend_vld_in  = 1'b0;
                     state_in     = S_SCAN;
                  end
                  REQ_CLEAR: begin
                     row_count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            if (absorb) begin
               eval_vld_in = issue;
               if (issue) begin
                  issue_cnt_in = issue_cnt_ff + CNT_BITS'(1);
               end
               if (eval_vld_ff && match) begin
                  pend_in     = compose(ram_rdata, prb_ff, cfg);
                  pend_vld_in = 1'b1;
                  if (pend_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_cols_in = pend_ff;
                     rsp_last_in = 1'b0;
                     rsp_stat_in = 1'b0;
                  end
               end
            end
            if (!more && !eval_vld_ff) begin
               if (!pend_vld_ff) begin
                  state_in = S_IDLE;
               end else if (out_free) begin
                  rsp_vld_in  = 1'b1;
                  rsp_cols_in = pend_ff;
                  rsp_last_in = 1'b1;
                  rsp_stat_in = 1'b0;
                  pend_vld_in = 1'b0;
                  state_in    = S_IDLE;
               end
            end
         end
         S_DROP: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_cols_in = '0;
               rsp_last_in = 1'b1;
               rsp_stat_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_count_ff <= '0;
         issue_cnt_ff <= '0;
         eval_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         issue_cnt_ff <= issue_cnt_in;
         eval_vld_ff  <= eval_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      prb_ff      <= prb_in;
      pend_ff     <= pend_in;
      rsp_cols_ff <= rsp_cols_in;
      rsp_last_ff <= rsp_last_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_cols       = rsp_cols_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_stat_ff;
   assign stat.busy      = (state_ff != S_IDLE);
   assign stat.row_count = row_count_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/equi_join_build_probe_core.sv -----
// ---------------------------------------------------------------------------
// Equi-join build/probe core
// Keeps a relation of build rows in a row store and joins each probe row
// against every stored row in insertion order on the configured key columns.
//
//   Channel   Prefix   Direction   Payload
//   request   req_     in          request code, four row columns
//   response  rsp_     out         eight joined columns, last, status
//   config    csr_     in          register index, write data
//
// A build or clear transaction is accepted while idle; a build into a full
// store is dropped and answered with a last status response after any stall.
// A probe scans every stored row in order: the scan reads one stored row
// per cycle from the single-port-read row store RAM unless a stall holds it.
// Reset empties the store at once; no clearing pass is needed.
// Response stalls hold the scan when a finished row waits and a match arrives.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module equi_join_build_probe_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [1:0]                          req_type,
   input  wire logic signed [31:0]                  req_col_0,
   input  wire logic signed [31:0]                  req_col_1,
   input  wire logic signed [31:0]                  req_col_2,
   input  wire logic signed [31:0]                  req_col_3,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [31:0]                       rsp_out_col_0,
   output logic signed [31:0]                       rsp_out_col_1,
   output logic signed [31:0]                       rsp_out_col_2,
   output logic signed [31:0]                       rsp_out_col_3,
   output logic signed [31:0]                       rsp_out_col_4,
   output logic signed [31:0]                       rsp_out_col_5,
   output logic signed [31:0]                       rsp_out_col_6,
   output logic signed [31:0]                       rsp_out_col_7,
   output logic                                     rsp_last,
   output logic                                     rsp_status,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ejbp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [ejbp_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   import ejbp_pkg::*;

   cfg_type     cfg;
   in_row_type  req_cols;
   out_row_type rsp_cols;
   ram_req_type ram_req;
   row_type     ram_rdata;
   stat_type    stat;

   assign req_cols[0] = req_col_0;
   assign req_cols[1] = req_col_1;
   assign req_cols[2] = req_col_2;
   assign req_cols[3] = req_col_3;

   assign rsp_out_col_0 = rsp_cols[0];
   assign rsp_out_col_1 = rsp_cols[1];
   assign rsp_out_col_2 = rsp_cols[2];
   assign rsp_out_col_3 = rsp_cols[3];
   assign rsp_out_col_4 = rsp_cols[4];
   assign rsp_out_col_5 = rsp_cols[5];
   assign rsp_out_col_6 = rsp_cols[6];
   assign rsp_out_col_7 = rsp_cols[7];

   ejbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ejbp_ram #(
      .WIDTH (MAX_COLS * VALUE_BITS),
      .DEPTH (MAX_ROWS)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_req.we),
      .wr_addr (ram_req.waddr),
      .wr_data (ram_req.wdata),
      .rd_en   (ram_req.re),
      .rd_addr (ram_req.raddr),
      .rd_data (ram_rdata)
   );

   ejbp_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_type   (req_type),
      .req_cols   (req_cols),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_cols   (rsp_cols),
      .rsp_last   (rsp_last),
      .rsp_status (rsp_status),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .stat       (stat)
   );

   `ASSERT_IMPLY(a_write_below_full, clock, reset, ram_req.we, stat.row_count < CNT_BITS'(MAX_ROWS))
   `ASSERT_ALWAYS(a_no_write_during_scan, clock, reset, !(ram_req.we && ram_req.re))
   `ASSERT_IMPLY(a_read_only_when_busy, clock, reset, ram_req.re, stat.busy)
   `ASSERT_IMPLY(a_drop_is_last, clock, reset, rsp_valid && rsp_status, rsp_last)

endmodule

`default_nettype wire
